// File: rtl/core/mpr_pkg.sv
`timescale 1ns / 1ps

package mpr_pkg;

  // Store geometry.
  localparam int unsigned LIFE        = 4;
  localparam int unsigned MAX_SAMPLES = 32768;
  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned STORE_DEPTH = LIFE * MAX_SAMPLES;

  localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
  localparam int unsigned SLOT_W  = (LIFE > 1) ? $clog2(LIFE) : 1;
  localparam int unsigned SIDX_W  = $clog2(MAX_SAMPLES + 2);
  localparam int unsigned COUNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned POS_W   = $clog2(MAX_DIM);
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);

  // Fixed field widths.
  localparam int unsigned CFG_DIM_W  = 13;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned PH_W       = 4;
  localparam int unsigned MAX_STEP   = 16;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 3 * CH_W;
  localparam int unsigned DIST_W     = 18;
  localparam int unsigned CNT_OUT_W  = 16;
  localparam int unsigned RATIO_W    = 17;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned CFG_IDX_W  = 3;

  // Frame-end ratio arithmetic.
  localparam int unsigned SQ_W   = 9;
  localparam int unsigned DEN_W  = 2 * DIM_W;
  localparam int unsigned NUM_W  = COUNT_W + SQ_W;
  localparam int unsigned REM_W  = (NUM_W > DEN_W + 1) ? NUM_W : DEN_W + 1;
  localparam int unsigned ITER_W = $clog2(RATIO_W);

  // Register reset values.
  localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = CFG_DIM_W'(480);
  localparam logic [STEP_W-1:0]    RST_STEP   = STEP_W'(4);
  localparam logic [CH_W-1:0]      RST_GTHR   = CH_W'(20);
  localparam logic [DIST_W-1:0]    RST_CTHR   = DIST_W'(400);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_SAMPLE_STEP  = 3'd2,
    CFG_COLOR_MODE   = 3'd3,
    CFG_GRAY_THR     = 3'd4,
    CFG_COLOR_THR_SQ = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL,
    DV_CHECK,
    DV_DIV,
    DV_DONE
  } div_state_e;

  typedef struct packed {
    logic [CH_W-1:0] chan0;
    logic [CH_W-1:0] chan1;
    logic [CH_W-1:0] chan2;
  } pix_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] moving_count;
    logic [RATIO_W-1:0]   moving_ratio;
    logic                 capacity_overflow;
  } res_t;

  typedef struct packed {
    logic               start;
    logic               ovf;
    logic [COUNT_W-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [STEP_W-1:0] step;
  } geom_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] v);
    logic [STEP_W-1:0] r;
    if (v == '0) begin
      r = STEP_W'(1);
    end else if (32'(v) > MAX_STEP) begin
      r = STEP_W'(MAX_STEP);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/mpr_ram.sv
`timescale 1ns / 1ps

// Single-port-write, single-port-read synchronous memory, registered read data.
module mpr_ram #(
  parameter int unsigned DATA_W = 24,
  parameter int unsigned DEPTH  = 1024,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mpr_motion_cmp.sv
`timescale 1ns / 1ps

// Decides whether a sample moved against its reference pixel.
module mpr_motion_cmp (
  input  logic [mpr_pkg::PIX_W-1:0]  cur_i,
  input  logic [mpr_pkg::PIX_W-1:0]  ref_i,
  input  logic                       color_i,
  input  logic [mpr_pkg::CH_W-1:0]   gray_thr_i,
  input  logic [mpr_pkg::DIST_W-1:0] color_thr_i,
  output logic                       moving_o
);

  function automatic logic [mpr_pkg::CH_W-1:0] abs_diff(
    input logic [mpr_pkg::CH_W-1:0] a,
    input logic [mpr_pkg::CH_W-1:0] b
  );
    return (a >= b) ? a - b : b - a;
  endfunction

  logic [mpr_pkg::CH_W-1:0]   d0, d1, d2;
  logic [2*mpr_pkg::CH_W-1:0] sq0, sq1, sq2;
  logic [mpr_pkg::DIST_W-1:0] dist_sq;

  always_comb begin
    d0      = abs_diff(cur_i[7:0], ref_i[7:0]);
    d1      = abs_diff(cur_i[15:8], ref_i[15:8]);
    d2      = abs_diff(cur_i[23:16], ref_i[23:16]);
    sq0     = d0 * d0;
    sq1     = d1 * d1;
    sq2     = d2 * d2;
    dist_sq = mpr_pkg::DIST_W'(sq0) + mpr_pkg::DIST_W'(sq1) + mpr_pkg::DIST_W'(sq2);
    if (color_i) begin
      moving_o = dist_sq > color_thr_i;
    end else begin
      moving_o = d0 > gray_thr_i;
    end
  end

endmodule

// File: rtl/core/mpr_ratio_div.sv
`timescale 1ns / 1ps

// Frame-end unit: forms count*step*step and width*height, then divides one
// quotient bit per cycle unless saturated, and holds the finished result item.
module mpr_ratio_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpr_pkg::div_req_t req_i,
  input  mpr_pkg::geom_t    geom_i,
  output logic              busy_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output mpr_pkg::res_t     res_o
);

  mpr_pkg::div_state_e state_q, state_d;

  logic [mpr_pkg::COUNT_W-1:0] cnt_q;
  logic                        ovf_q;
  logic [mpr_pkg::SQ_W-1:0]    sq_q;
  logic [mpr_pkg::DEN_W-1:0]   den_q;
  logic [mpr_pkg::REM_W-1:0]   num_q;
  logic [mpr_pkg::REM_W-1:0]   rem_q;
  logic [mpr_pkg::RATIO_W-1:0] quo_q;
  logic [mpr_pkg::ITER_W-1:0]  iter_q;

  logic [mpr_pkg::REM_W-1:0] den_ext;
  logic [mpr_pkg::REM_W-1:0] den_x2;
  logic                      saturate;
  logic                      qbit;
  logic [mpr_pkg::REM_W-1:0] rem_sub;
  logic                      last_iter;

  assign den_ext   = mpr_pkg::REM_W'(den_q);
  assign den_x2    = den_ext << 1;
  assign saturate  = num_q >= den_x2;
  assign qbit      = rem_q >= den_ext;
  assign rem_sub   = qbit ? rem_q - den_ext : rem_q;
  assign last_iter = iter_q == mpr_pkg::ITER_W'(mpr_pkg::RATIO_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpr_pkg::DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    busy_o      = 1'b1;
    res_valid_o = 1'b0;
    case (state_q)
      mpr_pkg::DV_IDLE: begin
        busy_o = 1'b0;
        if (req_i.start) begin
          state_d = mpr_pkg::DV_MUL;
        end
      end
      mpr_pkg::DV_MUL: begin
        state_d = mpr_pkg::DV_CHECK;
      end
      mpr_pkg::DV_CHECK: begin
        state_d = saturate ? mpr_pkg::DV_DONE : mpr_pkg::DV_DIV;
      end
      mpr_pkg::DV_DIV: begin
        if (last_iter) begin
          state_d = mpr_pkg::DV_DONE;
        end
      end
      mpr_pkg::DV_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = mpr_pkg::DV_IDLE;
        end
      end
      default: begin
        state_d = mpr_pkg::DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mpr_pkg::DV_IDLE: begin
        if (req_i.start) begin
          cnt_q <= req_i.count;
          ovf_q <= req_i.ovf;
          sq_q  <= mpr_pkg::SQ_W'(geom_i.step * geom_i.step);
          den_q <= mpr_pkg::DEN_W'(geom_i.width) * mpr_pkg::DEN_W'(geom_i.height);
        end
      end
      mpr_pkg::DV_MUL: begin
        num_q <= mpr_pkg::REM_W'(cnt_q) * mpr_pkg::REM_W'(sq_q);
      end
      mpr_pkg::DV_CHECK: begin
        rem_q  <= num_q;
        iter_q <= '0;
        quo_q  <= saturate ? '1 : '0;
      end
      mpr_pkg::DV_DIV: begin
        rem_q  <= rem_sub << 1;
        quo_q  <= {quo_q[mpr_pkg::RATIO_W-2:0], qbit};
        iter_q <= iter_q + mpr_pkg::ITER_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.moving_count = (32'(cnt_q) > 32'hFFFF) ? '1 : mpr_pkg::CNT_OUT_W'(cnt_q);
    res_o.moving_ratio = quo_q;
    res_o.capacity_overflow = ovf_q;
  end

`ifndef ASSERT_OFF
  a_start_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == mpr_pkg::DV_IDLE)
    else $error("frame-end request while ratio unit busy");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpr_pkg::DV_DIV |-> rem_q < den_x2)
    else $error("partial remainder out of range");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o)))
    else $error("waiting result item changed or was dropped");
`endif

endmodule

// File: rtl/core/moving_pixel_ratio.sv
`timescale 1ns / 1ps

// Moving pixel ratio. Pixels stream in raster order, one item per handshake;
// on every sample_step-th column of every sample_step-th row the pixel is
// compared with the sample stored at the same place LIFE frames earlier
// (gray: absolute difference over gray_threshold; color: squared channel
// distance over color_threshold_sq), and then replaces it. The last pixel of
// each frame produces one result item with the moving count, the ratio
// count*step*step/(width*height) in Q1.16 (saturating) and the overflow flag.
// The block accepts one item per cycle unless a frame's last pixel is held
// off: each sample within capacity does one read of the frame store at
// acceptance and one write-back in the following cycle, with a bypass when
// the write and the next read hit the same entry. Once the last pixel of a
// frame is accepted it passes the compare stage, the products and the
// saturation check, then one quotient bit per cycle for 17 bits, before the
// result item appears; a saturating ratio skips the division. The last
// pixel of a frame is held off only while the previous frame's result is
// still being computed or has not been taken. The frame store needs no
// clearing pass after reset; per-slot filled bits decide whether the stored
// samples are used.
// Configuration writes must happen while the block is idle; writing the
// width, height, step or color mode restarts the frame history.
module moving_pixel_ratio (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mpr_pkg::pix_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mpr_pkg::res_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [mpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mpr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  // Configuration registers.
  logic [mpr_pkg::CFG_DIM_W-1:0] width_q, height_q;
  logic [mpr_pkg::STEP_W-1:0]    step_q;
  logic                          color_q;
  logic [mpr_pkg::CH_W-1:0]      gthr_q;
  logic [mpr_pkg::DIST_W-1:0]    cthr_q;
  logic                          restart;

  // Raster position and history bookkeeping (accept stage).
  logic [mpr_pkg::POS_W-1:0]  col_q, col_d, row_q, row_d;
  logic [mpr_pkg::PH_W-1:0]   cph_q, cph_d, rph_q, rph_d;
  logic [mpr_pkg::SIDX_W-1:0] sidx_q, sidx_d;
  logic [mpr_pkg::SLOT_W-1:0] phase_q, phase_d;
  logic [mpr_pkg::ADDR_W-1:0] base_q, base_d;
  logic [mpr_pkg::LIFE-1:0]   filled_q, filled_d;

  // Compare stage.
  logic                       b_valid_q, b_cmp_q, b_filled_q, b_end_q, b_ovf_q, b_byp_q;
  logic [mpr_pkg::ADDR_W-1:0] b_addr_q;
  logic [mpr_pkg::PIX_W-1:0]  b_cur_q, b_byp_data_q;
  logic [mpr_pkg::COUNT_W-1:0] cnt_q, cnt_d;

  mpr_pkg::geom_t             geom;
  logic                       last_col, last_row, last_cph, last_rph, frame_end;
  logic                       is_sample, in_cap, do_rd, in_fire, end_busy, byp_hit;
  logic [mpr_pkg::ADDR_W-1:0] rd_addr;
  logic [mpr_pkg::PIX_W-1:0]  cur_pix, rd_data, ref_pix, empty_ref, pix_mask;
  logic                       moving, wr_en, div_busy;
  mpr_pkg::div_req_t          div_req;

  // Configuration port.
  assign restart = cfg_we_i && (cfg_idx_i == mpr_pkg::CFG_FRAME_WIDTH  ||
                                cfg_idx_i == mpr_pkg::CFG_FRAME_HEIGHT ||
                                cfg_idx_i == mpr_pkg::CFG_SAMPLE_STEP  ||
                                cfg_idx_i == mpr_pkg::CFG_COLOR_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mpr_pkg::RST_WIDTH;
      height_q <= mpr_pkg::RST_HEIGHT;
      step_q   <= mpr_pkg::RST_STEP;
      color_q  <= 1'b0;
      gthr_q   <= mpr_pkg::RST_GTHR;
      cthr_q   <= mpr_pkg::RST_CTHR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpr_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[mpr_pkg::CFG_DIM_W-1:0];
        mpr_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_wdata_i[mpr_pkg::CFG_DIM_W-1:0];
        mpr_pkg::CFG_SAMPLE_STEP:  step_q   <= cfg_wdata_i[mpr_pkg::STEP_W-1:0];
        mpr_pkg::CFG_COLOR_MODE:   color_q  <= cfg_wdata_i[0];
        mpr_pkg::CFG_GRAY_THR:     gthr_q   <= cfg_wdata_i[mpr_pkg::CH_W-1:0];
        mpr_pkg::CFG_COLOR_THR_SQ: cthr_q   <= cfg_wdata_i[mpr_pkg::DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign geom.width  = mpr_pkg::clamp_dim(width_q);
  assign geom.height = mpr_pkg::clamp_dim(height_q);
  assign geom.step   = mpr_pkg::clamp_step(step_q);

  // Raster tracking. Sampling phases count the stride in rows and columns,
  // so a sample falls where both phases are zero.
  assign last_col  = (mpr_pkg::DIM_W'(col_q) + mpr_pkg::DIM_W'(1)) == geom.width;
  assign last_row  = (mpr_pkg::DIM_W'(row_q) + mpr_pkg::DIM_W'(1)) == geom.height;
  assign last_cph  = (mpr_pkg::STEP_W'(cph_q) + mpr_pkg::STEP_W'(1)) == geom.step;
  assign last_rph  = (mpr_pkg::STEP_W'(rph_q) + mpr_pkg::STEP_W'(1)) == geom.step;
  assign frame_end = last_col && last_row;

  assign is_sample = (cph_q == '0) && (rph_q == '0);
  assign in_cap    = 32'(sidx_q) < mpr_pkg::MAX_SAMPLES;
  assign do_rd     = is_sample && in_cap;
  assign rd_addr   = base_q + mpr_pkg::ADDR_W'(sidx_q);

  // Only the last pixel of a frame waits, and only while the ratio unit is
  // taken by the previous frame (or about to be).
  assign end_busy   = div_busy || (b_valid_q && b_end_q);
  assign in_ready_o = !(frame_end && end_busy);
  assign in_fire    = in_valid_i && in_ready_o;

  // In gray mode the upper channels are forced to zero before use or storage.
  assign cur_pix  = {color_q ? in_data_i.chan2 : '0,
                     color_q ? in_data_i.chan1 : '0,
                     in_data_i.chan0};
  assign pix_mask = color_q ? '1 : mpr_pkg::PIX_W'({mpr_pkg::CH_W{1'b1}});

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    cph_d    = cph_q;
    rph_d    = rph_q;
    sidx_d   = sidx_q;
    phase_d  = phase_q;
    base_d   = base_q;
    filled_d = filled_q;
    if (in_fire) begin
      if (is_sample && 32'(sidx_q) <= mpr_pkg::MAX_SAMPLES) begin
        sidx_d = sidx_q + mpr_pkg::SIDX_W'(1);
      end
      if (last_col) begin
        col_d = '0;
        cph_d = '0;
        if (frame_end) begin
          row_d  = '0;
          rph_d  = '0;
          sidx_d = '0;
          filled_d[phase_q] = 1'b1;
          if (32'(phase_q) == mpr_pkg::LIFE - 1) begin
            phase_d = '0;
            base_d  = '0;
          end else begin
            phase_d = phase_q + mpr_pkg::SLOT_W'(1);
            base_d  = base_q + mpr_pkg::ADDR_W'(mpr_pkg::MAX_SAMPLES);
          end
        end else begin
          row_d = row_q + mpr_pkg::POS_W'(1);
          rph_d = last_rph ? '0 : rph_q + mpr_pkg::PH_W'(1);
        end
      end else begin
        col_d = col_q + mpr_pkg::POS_W'(1);
        cph_d = last_cph ? '0 : cph_q + mpr_pkg::PH_W'(1);
      end
    end
    if (restart) begin
      col_d    = '0;
      row_d    = '0;
      cph_d    = '0;
      rph_d    = '0;
      sidx_d   = '0;
      phase_d  = '0;
      base_d   = '0;
      filled_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      cph_q     <= '0;
      rph_q     <= '0;
      sidx_q    <= '0;
      phase_q   <= '0;
      base_q    <= '0;
      filled_q  <= '0;
      b_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      cph_q     <= cph_d;
      rph_q     <= rph_d;
      sidx_q    <= sidx_d;
      phase_q   <= phase_d;
      base_q    <= base_d;
      filled_q  <= filled_d;
      b_valid_q <= in_fire;
      cnt_q     <= cnt_d;
    end
  end

  // The write-back of the sample in the compare stage lands at the same edge
  // as the next read; when both hit one entry the read would see stale data,
  // so the written pixel is carried along instead.
  assign wr_en   = b_valid_q && b_cmp_q;
  assign byp_hit = wr_en && do_rd && (b_addr_q == rd_addr);

  // The overflow flag of a frame looks at the sample index after this pixel
  // has been counted, before the frame end clears it.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_cmp_q      <= do_rd;
      b_filled_q   <= filled_q[phase_q];
      b_end_q      <= frame_end;
      b_ovf_q      <= (32'(sidx_q) > mpr_pkg::MAX_SAMPLES) ||
                      (is_sample && 32'(sidx_q) == mpr_pkg::MAX_SAMPLES);
      b_addr_q     <= rd_addr;
      b_cur_q      <= cur_pix;
      b_byp_q      <= byp_hit;
      b_byp_data_q <= b_cur_q;
    end
  end

  mpr_ram #(
    .DATA_W(mpr_pkg::PIX_W),
    .DEPTH (mpr_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(b_addr_q),
    .wdata_i(b_cur_q),
    .re_i   (in_fire && do_rd),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // An empty slot compares against the complement of the current pixel.
  assign empty_ref = ~b_cur_q & pix_mask;
  assign ref_pix   = !b_filled_q ? empty_ref : (b_byp_q ? b_byp_data_q : rd_data);

  mpr_motion_cmp u_cmp (
    .cur_i      (b_cur_q),
    .ref_i      (ref_pix),
    .color_i    (color_q),
    .gray_thr_i (gthr_q),
    .color_thr_i(cthr_q),
    .moving_o   (moving)
  );

  always_comb begin
    div_req.start = b_valid_q && b_end_q;
    div_req.ovf   = b_ovf_q;
    div_req.count = cnt_q + mpr_pkg::COUNT_W'(wr_en && moving);
    cnt_d = cnt_q;
    if (b_valid_q) begin
      cnt_d = b_end_q ? '0 : div_req.count;
    end
    if (restart) begin
      cnt_d = '0;
    end
  end

  mpr_ratio_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .geom_i     (geom),
    .busy_o     (div_busy),
    .res_valid_o(out_valid_o),
    .res_ready_i(out_ready_i),
    .res_o      (out_data_o)
  );

`ifndef ASSERT_OFF
  a_sidx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sidx_q) <= mpr_pkg::MAX_SAMPLES + 1)
    else $error("sample index ran past its saturation point");

  a_addr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> 32'(b_addr_q) < mpr_pkg::STORE_DEPTH)
    else $error("frame store write outside the store");

  a_end_starts_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && frame_end && !restart) |=> (div_req.start && !$past(div_busy)))
    else $error("frame end did not launch the ratio unit");
`endif

endmodule

// File: tb/motion_ratio_checker.sv
`timescale 1ns / 1ps

// Watches the pixel, result and configuration ports of the motion ratio block.
// It keeps its own copy of the frame history and predicts each frame result.
module motion_ratio_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  mpr_pkg::pix_t                  in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  mpr_pkg::res_t                  out_data_i,
  input  logic                           cfg_we_i,
  input  logic [mpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mpr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                    pending_o,
  output int unsigned                    mismatches_o
);

  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [4:0]  step_reg;
  logic        color_reg;
  logic [7:0]  gray_thr_reg;
  logic [17:0] color_thr_reg;

  mpr_pkg::pix_t pixel_history [mpr_pkg::LIFE * mpr_pkg::MAX_SAMPLES];
  bit            slot_used [mpr_pkg::LIFE];
  int unsigned   cur_slot;
  int unsigned   col_pos;
  int unsigned   row_pos;
  int unsigned   sample_idx;
  int unsigned   moving_tally;

  mpr_pkg::res_t frame_result_q [$];
  mpr_pkg::res_t expected_frame;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatches_o < 100) begin
      $display("%0t ns: %s is wrong, expected %0d, got %0d", $realtime, what, want, got);
    end
    mismatches_o++;
  endtask

  task automatic restart_frames();
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
    end
    cur_slot     = 0;
    col_pos      = 0;
    row_pos      = 0;
    sample_idx   = 0;
    moving_tally = 0;
  endtask

  task automatic apply_setting(input logic [mpr_pkg::CFG_IDX_W-1:0] idx,
                               input logic [mpr_pkg::CFG_DATA_W-1:0] value);
    case (mpr_pkg::cfg_reg_e'(idx))
      mpr_pkg::CFG_FRAME_WIDTH: begin
        width_reg = value[12:0];
        restart_frames();
      end
      mpr_pkg::CFG_FRAME_HEIGHT: begin
        height_reg = value[12:0];
        restart_frames();
      end
      mpr_pkg::CFG_SAMPLE_STEP: begin
        step_reg = value[4:0];
        restart_frames();
      end
      mpr_pkg::CFG_COLOR_MODE: begin
        color_reg = value[0];
        restart_frames();
      end
      mpr_pkg::CFG_GRAY_THR: begin
        gray_thr_reg = value[7:0];
      end
      mpr_pkg::CFG_COLOR_THR_SQ: begin
        color_thr_reg = value[17:0];
      end
      default: begin
      end
    endcase
  endtask

  // Advances the raster position by one pixel and queues a result on the last
  // pixel of a frame.
  task automatic judge_pixel(input mpr_pkg::pix_t px);
    int unsigned       w;
    int unsigned       h;
    int unsigned       s;
    int unsigned       addr;
    int unsigned       distance_sq;
    int unsigned       gray_diff;
    int                d0;
    int                d1;
    int                d2;
    bit                moving;
    mpr_pkg::pix_t     cur;
    mpr_pkg::pix_t     prior;
    mpr_pkg::res_t     res;
    longint unsigned   ratio;
    longint unsigned   ratio_cap;
    w = (width_reg == 0) ? 1 : ((width_reg > mpr_pkg::MAX_DIM) ? mpr_pkg::MAX_DIM : width_reg);
    h = (height_reg == 0) ? 1 :
        ((height_reg > mpr_pkg::MAX_DIM) ? mpr_pkg::MAX_DIM : height_reg);
    s = (step_reg == 0) ? 1 : ((step_reg > 16) ? 16 : step_reg);
    ratio_cap = (64'd1 << mpr_pkg::RATIO_W) - 1;
    cur = px;
    if (!color_reg) begin
      cur.chan1 = '0;
      cur.chan2 = '0;
    end
    if ((row_pos % s) == 0 && (col_pos % s) == 0) begin
      if (sample_idx < mpr_pkg::MAX_SAMPLES) begin
        addr = cur_slot * mpr_pkg::MAX_SAMPLES + sample_idx;
        // A slot that has never held a frame compares against the inverted pixel.
        if (slot_used[cur_slot]) begin
          prior = pixel_history[addr];
        end else begin
          prior = ~cur;
        end
        d0 = int'(cur.chan0) - int'(prior.chan0);
        d1 = int'(cur.chan1) - int'(prior.chan1);
        d2 = int'(cur.chan2) - int'(prior.chan2);
        if (color_reg) begin
          distance_sq = d0 * d0 + d1 * d1 + d2 * d2;
          moving = distance_sq > color_thr_reg;
        end else begin
          gray_diff = (d0 < 0) ? -d0 : d0;
          moving = gray_diff > gray_thr_reg;
        end
        if (moving) begin
          moving_tally++;
        end
        pixel_history[addr] = cur;
      end
      if (sample_idx <= mpr_pkg::MAX_SAMPLES) begin
        sample_idx++;
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        ratio = (longint'(moving_tally) * s * s * 64'd65536) / (longint'(w) * longint'(h));
        if (ratio > ratio_cap) begin
          ratio = ratio_cap;
        end
        res.moving_count      = (moving_tally > 16'hFFFF) ? 16'hFFFF : 16'(moving_tally);
        res.moving_ratio      = ratio[mpr_pkg::RATIO_W-1:0];
        res.capacity_overflow = sample_idx > mpr_pkg::MAX_SAMPLES;
        frame_result_q.push_back(res);
        slot_used[cur_slot] = 1'b1;
        cur_slot     = (cur_slot + 1) % mpr_pkg::LIFE;
        row_pos      = 0;
        sample_idx   = 0;
        moving_tally = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg     = mpr_pkg::RST_WIDTH;
      height_reg    = mpr_pkg::RST_HEIGHT;
      step_reg      = mpr_pkg::RST_STEP;
      color_reg     = 1'b0;
      gray_thr_reg  = mpr_pkg::RST_GTHR;
      color_thr_reg = mpr_pkg::RST_CTHR;
      restart_frames();
      frame_result_q.delete();
      mismatches_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (frame_result_q.size() == 0) begin
          report_mismatch("result item with no frame pending, moving_count", 0,
                          out_data_i.moving_count);
        end else begin
          expected_frame = frame_result_q.pop_front();
          if (out_data_i.moving_count != expected_frame.moving_count) begin
            report_mismatch("moving_count", expected_frame.moving_count,
                            out_data_i.moving_count);
          end
          if (out_data_i.moving_ratio != expected_frame.moving_ratio) begin
            report_mismatch("moving_ratio", expected_frame.moving_ratio,
                            out_data_i.moving_ratio);
          end
          if (out_data_i.capacity_overflow != expected_frame.capacity_overflow) begin
            report_mismatch("capacity_overflow", expected_frame.capacity_overflow,
                            out_data_i.capacity_overflow);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        judge_pixel(in_data_i);
      end
      if (cfg_we_i) begin
        apply_setting(cfg_idx_i, cfg_wdata_i);
      end
    end
    pending_o = frame_result_q.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Top of the motion ratio bench. This module only produces stimulus and gives
// the verdict; the checker beside the block predicts and compares every frame
// result item.
module testbench;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           pix_valid = 1'b0;
  logic                           pix_ready;
  mpr_pkg::pix_t                  pix_data  = '0;
  logic                           res_valid;
  logic                           res_ready = 1'b0;
  mpr_pkg::res_t                  res_data;
  logic                           cfg_we    = 1'b0;
  logic [mpr_pkg::CFG_IDX_W-1:0]  cfg_idx   = mpr_pkg::CFG_FRAME_WIDTH;
  logic [mpr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned pending;
  int unsigned mismatches;

  // When set, both the pixel source and the result sink run without gaps.
  bit          quiet = 1'b0;
  int unsigned results_taken = 0;

  // Reference picture of the random part; each frame is a noisy copy of it,
  // so that differences land close to the thresholds.
  mpr_pkg::pix_t scene [64];

  always #6 clk = ~clk;

  moving_pixel_ratio DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (pix_valid),
    .in_ready_o  (pix_ready),
    .in_data_i   (pix_data),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_data_o  (res_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  motion_ratio_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (pix_valid),
    .in_ready_i   (pix_ready),
    .in_data_i    (pix_data),
    .out_valid_i  (res_valid),
    .out_ready_i  (res_ready),
    .out_data_i   (res_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  function automatic mpr_pkg::pix_t random_pixel();
    mpr_pkg::pix_t px;
    px.chan0 = 8'($urandom);
    px.chan1 = 8'($urandom);
    px.chan2 = 8'($urandom);
    return px;
  endfunction

  // Gray pixel with junk in the two color channels, which gray mode must ignore.
  function automatic mpr_pkg::pix_t gray_px(input logic [7:0] value);
    mpr_pkg::pix_t px;
    px       = random_pixel();
    px.chan0 = value;
    return px;
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 48)) - 24;
    if (v < 0) begin
      v = 0;
    end else if (v > 255) begin
      v = 255;
    end
    return 8'(v);
  endfunction

  // A quarter of the pixels repeat the scene exactly, most are close to it and
  // a few are unrelated.
  function automatic mpr_pkg::pix_t scene_pixel(input int unsigned pos);
    mpr_pkg::pix_t px;
    case ($urandom_range(0, 7))
      0: begin
        px = random_pixel();
      end
      1, 2: begin
        px = scene[pos];
      end
      default: begin
        px.chan0 = nudge(scene[pos].chan0);
        px.chan1 = nudge(scene[pos].chan1);
        px.chan2 = nudge(scene[pos].chan2);
      end
    endcase
    return px;
  endfunction

  // Presents one pixel item after a random gap and holds it until accepted.
  // Valid stays high across back-to-back items.
  task automatic send_pixel(input mpr_pkg::pix_t px);
    int unsigned gap;
    gap = quiet ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 16));
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_data  <= px;
    do @(posedge clk); while (!pix_ready);
  endtask

  // Brings the block to rest before a register write: every frame result has
  // been taken, and the last accepted pixel has finished its store write-back.
  task automatic settle();
    pix_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input mpr_pkg::cfg_reg_e idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= mpr_pkg::CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  // Result sink: draws a stall for every result item, then waits for it.
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      stall = quiet ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 16));
      if (stall != 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      results_taken++;
    end
  end

  // The run can not legally take this long; a hang ends here.
  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [7:0]  gray_run [13];
    int unsigned rand_items;
    int unsigned width_set;
    int unsigned height_set;
    int unsigned frame_px;
    int unsigned total_px;
    int unsigned waited;
    bit          new_geometry;

    gray_run = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd20, 8'd235, 8'd0, 8'd0,
                 8'd20, 8'd234, 8'd127, 8'd128, 8'd55};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Gray frames of two pixels, threshold left at its reset value. The first
    // four frames fill the history ring against inverted pixels (0 against
    // 255, 127 against 128); the next two compare with real history, where a
    // difference of exactly the threshold does not count and one more does.
    // The last pixel leaves a frame unfinished.
    write_reg(mpr_pkg::CFG_FRAME_WIDTH, 2);
    write_reg(mpr_pkg::CFG_FRAME_HEIGHT, 1);
    write_reg(mpr_pkg::CFG_SAMPLE_STEP, 1);
    write_reg(mpr_pkg::CFG_COLOR_MODE, 0);
    cfg_we <= 1'b0;
    foreach (gray_run[i]) begin
      send_pixel(gray_px(gray_run[i]));
    end

    // Color mode restarts the unfinished frame. Black and white against their
    // inverses sit exactly on the largest threshold; then the threshold drops
    // to zero without a restart.
    settle();
    write_reg(mpr_pkg::CFG_COLOR_MODE, 1);
    write_reg(mpr_pkg::CFG_FRAME_WIDTH, 1);
    write_reg(mpr_pkg::CFG_FRAME_HEIGHT, 2);
    write_reg(mpr_pkg::CFG_COLOR_THR_SQ, 195075);
    write_reg(mpr_pkg::CFG_GRAY_THR, 255);
    cfg_we <= 1'b0;
    send_pixel('{chan0: 8'd0, chan1: 8'd0, chan2: 8'd0});
    send_pixel('{chan0: 8'd255, chan1: 8'd255, chan2: 8'd255});
    settle();
    write_reg(mpr_pkg::CFG_COLOR_THR_SQ, 0);
    cfg_we <= 1'b0;
    send_pixel('{chan0: 8'd10, chan1: 8'd20, chan2: 8'd30});
    send_pixel('{chan0: 8'd1, chan1: 8'd2, chan2: 8'd3});

    // Zero width and height act as one pixel, an oversized step as 16: every
    // frame is a single moving sample and the ratio saturates.
    settle();
    write_reg(mpr_pkg::CFG_FRAME_WIDTH, 0);
    write_reg(mpr_pkg::CFG_FRAME_HEIGHT, 0);
    write_reg(mpr_pkg::CFG_SAMPLE_STEP, 31);
    write_reg(mpr_pkg::CFG_COLOR_MODE, 0);
    write_reg(mpr_pkg::CFG_GRAY_THR, 0);
    cfg_we <= 1'b0;
    send_pixel(gray_px(8'd0));
    send_pixel(gray_px(8'd128));
    send_pixel(gray_px(8'd255));

    // Random part: small frames so that results come often. Geometry mostly
    // stays put across phases so the history ring is compared against real
    // data; thresholds change every phase. Some phases stop mid-frame.
    rand_items   = 0;
    width_set    = 1;
    height_set   = 1;
    new_geometry = 1'b1;
    while (rand_items < 450 || results_taken < 48) begin
      settle();
      if (new_geometry) begin
        width_set  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        height_set = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        write_reg(mpr_pkg::CFG_FRAME_WIDTH, width_set);
        write_reg(mpr_pkg::CFG_FRAME_HEIGHT, height_set);
        write_reg(mpr_pkg::CFG_SAMPLE_STEP,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(16, 31)
                                              : $urandom_range(0, 4));
        write_reg(mpr_pkg::CFG_COLOR_MODE, $urandom_range(0, 1));
      end
      if (new_geometry || $urandom_range(0, 3) == 0) begin
        foreach (scene[i]) begin
          scene[i] = random_pixel();
        end
      end
      case ($urandom_range(0, 3))
        0:       write_reg(mpr_pkg::CFG_GRAY_THR, 0);
        1:       write_reg(mpr_pkg::CFG_GRAY_THR, 255);
        default: write_reg(mpr_pkg::CFG_GRAY_THR, $urandom_range(0, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(mpr_pkg::CFG_COLOR_THR_SQ, 0);
        1:       write_reg(mpr_pkg::CFG_COLOR_THR_SQ, 195075);
        2:       write_reg(mpr_pkg::CFG_COLOR_THR_SQ, 262143);
        default: write_reg(mpr_pkg::CFG_COLOR_THR_SQ, $urandom_range(0, 2000));
      endcase
      cfg_we <= 1'b0;

      quiet    = ($urandom_range(0, 3) == 0);
      frame_px = ((width_set == 0) ? 1 : width_set) * ((height_set == 0) ? 1 : height_set);
      total_px = frame_px * $urandom_range(1, 6);
      if (frame_px > 1 && $urandom_range(0, 3) == 0) begin
        total_px += $urandom_range(1, frame_px - 1);
      end
      for (int unsigned n = 0; n < total_px; n++) begin
        send_pixel(scene_pixel(n % frame_px));
        rand_items++;
      end
      new_geometry = ($urandom_range(0, 2) == 0);
    end

    // Drain: wait for every predicted result, then for the block's latency.
    pix_valid <= 1'b0;
    quiet = 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 5000);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mpr_pkg.sv
rtl/core/mpr_ram.sv
rtl/core/mpr_motion_cmp.sv
rtl/core/mpr_ratio_div.sv
rtl/core/moving_pixel_ratio.sv
tb/motion_ratio_checker.sv
tb/testbench.sv
